FILE: rtl/rfd_pkg.sv
// Shared codes and widths for the reply frame deframer.
package rfd_pkg;

  localparam int unsigned OpW    = 2;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 16;
  localparam int unsigned KindW  = 2;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned HdrW   = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW   = 16;

  // Input operation codes
  localparam logic [OpW-1:0] OP_BYTE  = 2'd0;
  localparam logic [OpW-1:0] OP_TICK  = 2'd1;
  localparam logic [OpW-1:0] OP_START = 2'd2;

  // Result kinds
  localparam logic [KindW-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KindW-1:0] KIND_EMPTY   = 2'd1;
  localparam logic [KindW-1:0] KIND_TOOBIG  = 2'd2;
  localparam logic [KindW-1:0] KIND_TIMEOUT = 2'd3;

  // Phase codes
  localparam logic [PhaseW-1:0] PH_FINISHED = 3'd0;
  localparam logic [PhaseW-1:0] PH_HUNT     = 3'd1;
  localparam logic [PhaseW-1:0] PH_HEADER   = 3'd2;
  localparam logic [PhaseW-1:0] PH_PAYLOAD  = 3'd3;
  localparam logic [PhaseW-1:0] PH_DISCARD  = 3'd4;

  // Header byte positions after the sync byte
  localparam logic [HdrW-1:0] HDR_OPCODE = 2'd0;
  localparam logic [HdrW-1:0] HDR_ID     = 2'd1;
  localparam logic [HdrW-1:0] HDR_LEN_LO = 2'd2;
  localparam logic [HdrW-1:0] HDR_LEN_HI = 2'd3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_WANT_OPCODE   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_WANT_ID       = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_BUFFER_LIMIT  = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT_TICKS = 2'd3;

  localparam logic [ByteW-1:0] SYNC_REPLY = 8'hF8;
  localparam logic [ByteW-1:0] SYNC_CMD   = 8'hF7;

  localparam logic [LenW-1:0] BUFFER_LIMIT_RST = 16'd8192;

endpackage

FILE: rtl/reply_frame_deframer_core.sv
// Reply frame deframer: hunts sync bytes, parses headers, passes out a matching payload.
//
// The block takes one request per cycle: a received byte, a time tick or a start
// command. Each accepted request is captured in an input register; once the
// result register is free or being taken, a short update of the frame state
// machine consumes it and, when the request causes a result, loads the result
// register. A result thus passes both registers in turn; the sustained rate is
// one request per clock as long as results are taken. When the result register
// is full and not taken, the input register holds its request and in_ready_o
// drops until the result register frees. Bytes other than 0xF8 and 0xF7 are
// skipped while hunting; a frame is sync, opcode, id, length low, length high
// and the payload. A 0xF8 frame whose opcode and id match the configured values
// has its payload passed out byte by byte, the last byte marked; an empty one
// gives a single empty-reply status, and one longer than buffer_limit is
// skipped and then reported as too big. With a nonzero timeout_ticks a
// timeout status is given on the tick after timeout_ticks counted ticks while
// no match has been found. After any finishing result the block ignores bytes
// and ticks until a start request. Write configuration only while idle.
module reply_frame_deframer_core
  import rfd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [OpW-1:0]     operation_i,
  input  logic [ByteW-1:0]   rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [KindW-1:0]   kind_o,
  output logic [ByteW-1:0]   data_o,
  output logic               is_last_o,
  output logic [LenW-1:0]    length_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  // Configuration registers
  logic [ByteW-1:0] want_opcode_q, want_id_q;
  logic [LenW-1:0]  buffer_limit_q, timeout_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      want_opcode_q   <= '0;
      want_id_q       <= '0;
      buffer_limit_q  <= BUFFER_LIMIT_RST;
      timeout_ticks_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_WANT_OPCODE:   want_opcode_q   <= cfg_data_i[ByteW-1:0];
        REG_WANT_ID:       want_id_q       <= cfg_data_i[ByteW-1:0];
        REG_BUFFER_LIMIT:  buffer_limit_q  <= cfg_data_i[LenW-1:0];
        REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // Input register: hold the request until the result side can take its outcome
  logic             stg_valid_q;
  logic [OpW-1:0]   stg_op_q;
  logic [ByteW-1:0] stg_byte_q;
  logic             advance;

  assign advance    = stg_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !stg_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      stg_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      stg_op_q   <= operation_i;
      stg_byte_q <= rx_byte_i;
    end
  end

  // Frame state
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [HdrW-1:0]   hdr_idx_q, hdr_idx_d;
  logic              is_reply_q, is_reply_d;
  logic [ByteW-1:0]  frame_opcode_q, frame_opcode_d;
  logic [ByteW-1:0]  frame_id_q, frame_id_d;
  logic [LenW-1:0]   frame_len_q, frame_len_d;
  logic [LenW-1:0]   bytes_rem_q, bytes_rem_d;
  logic [LenW-1:0]   tick_cnt_q, tick_cnt_d;
  logic              fin_after_q, fin_after_d;

  // Result of the current request
  logic              res_emit;
  logic [KindW-1:0]  res_kind;
  logic [ByteW-1:0]  res_data;
  logic              res_last;
  logic [LenW-1:0]   res_len;

  logic [LenW-1:0]   rem_dec;
  logic [LenW-1:0]   hdr_len;
  logic              hdr_match;
  logic              counting;

  assign rem_dec   = bytes_rem_q - LenW'(1);
  assign hdr_len   = {stg_byte_q, frame_len_q[ByteW-1:0]};
  assign hdr_match = is_reply_q && (frame_opcode_q == want_opcode_q) &&
                     (frame_id_q == want_id_q);
  assign counting  = (phase_q == PH_HUNT) || (phase_q == PH_HEADER) ||
                     ((phase_q == PH_DISCARD) && !fin_after_q);

  always_comb begin
    phase_d        = phase_q;
    hdr_idx_d      = hdr_idx_q;
    is_reply_d     = is_reply_q;
    frame_opcode_d = frame_opcode_q;
    frame_id_d     = frame_id_q;
    frame_len_d    = frame_len_q;
    bytes_rem_d    = bytes_rem_q;
    tick_cnt_d     = tick_cnt_q;
    fin_after_d    = fin_after_q;
    res_emit       = 1'b0;
    res_kind       = KIND_PAYLOAD;
    res_data       = '0;
    res_last       = 1'b0;
    res_len        = '0;

    case (stg_op_q)
      OP_BYTE: begin
        case (phase_q)
          PH_HUNT: begin
            if (stg_byte_q == SYNC_REPLY || stg_byte_q == SYNC_CMD) begin
              is_reply_d = (stg_byte_q == SYNC_REPLY);
              hdr_idx_d  = HDR_OPCODE;
              phase_d    = PH_HEADER;
            end
          end
          PH_HEADER: begin
            case (hdr_idx_q)
              HDR_OPCODE: begin
                frame_opcode_d = stg_byte_q;
                hdr_idx_d      = HDR_ID;
              end
              HDR_ID: begin
                frame_id_d = stg_byte_q;
                hdr_idx_d  = HDR_LEN_LO;
              end
              HDR_LEN_LO: begin
                frame_len_d = {{(LenW-ByteW){1'b0}}, stg_byte_q};
                hdr_idx_d   = HDR_LEN_HI;
              end
              default: begin
                // Length complete: decide where the payload goes
                frame_len_d = hdr_len;
                hdr_idx_d   = HDR_OPCODE;
                bytes_rem_d = hdr_len;
                if (hdr_match) begin
                  if (hdr_len <= buffer_limit_q) begin
                    if (hdr_len == '0) begin
                      phase_d  = PH_FINISHED;
                      res_emit = 1'b1;
                      res_kind = KIND_EMPTY;
                      res_last = 1'b1;
                    end else begin
                      phase_d = PH_PAYLOAD;
                    end
                  end else begin
                    fin_after_d = 1'b1;
                    phase_d     = PH_DISCARD;
                  end
                end else begin
                  fin_after_d = 1'b0;
                  phase_d     = (hdr_len == '0) ? PH_HUNT : PH_DISCARD;
                end
              end
            endcase
          end
          PH_PAYLOAD: begin
            bytes_rem_d = rem_dec;
            res_emit    = 1'b1;
            res_kind    = KIND_PAYLOAD;
            res_data    = stg_byte_q;
            res_len     = frame_len_q;
            if (rem_dec == '0) begin
              phase_d  = PH_FINISHED;
              res_last = 1'b1;
            end
          end
          PH_DISCARD: begin
            bytes_rem_d = rem_dec;
            if (rem_dec == '0) begin
              if (fin_after_q) begin
                fin_after_d = 1'b0;
                phase_d     = PH_FINISHED;
                res_emit    = 1'b1;
                res_kind    = KIND_TOOBIG;
                res_last    = 1'b1;
                res_len     = frame_len_q;
              end else begin
                phase_d = PH_HUNT;
              end
            end
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        if (counting && timeout_ticks_q != '0) begin
          if (tick_cnt_q >= timeout_ticks_q) begin
            // Abandon any partly read frame
            phase_d   = PH_FINISHED;
            hdr_idx_d = HDR_OPCODE;
            res_emit  = 1'b1;
            res_kind  = KIND_TIMEOUT;
            res_last  = 1'b1;
          end else begin
            tick_cnt_d = tick_cnt_q + LenW'(1);
          end
        end
      end
      OP_START: begin
        phase_d     = PH_HUNT;
        hdr_idx_d   = HDR_OPCODE;
        tick_cnt_d  = '0;
        fin_after_d = 1'b0;
        bytes_rem_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_FINISHED;
      hdr_idx_q      <= HDR_OPCODE;
      is_reply_q     <= 1'b0;
      frame_opcode_q <= '0;
      frame_id_q     <= '0;
      frame_len_q    <= '0;
      bytes_rem_q    <= '0;
      tick_cnt_q     <= '0;
      fin_after_q    <= 1'b0;
    end else if (advance) begin
      phase_q        <= phase_d;
      hdr_idx_q      <= hdr_idx_d;
      is_reply_q     <= is_reply_d;
      frame_opcode_q <= frame_opcode_d;
      frame_id_q     <= frame_id_d;
      frame_len_q    <= frame_len_d;
      bytes_rem_q    <= bytes_rem_d;
      tick_cnt_q     <= tick_cnt_d;
      fin_after_q    <= fin_after_d;
    end
  end

  // Result register: load on a producing request, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance) begin
      out_valid_o <= res_emit;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_emit) begin
      kind_o    <= res_kind;
      data_o    <= res_data;
      is_last_o <= res_last;
      length_o  <= res_len;
    end
  end

`ifndef ASSERT_OFF
  // No bytes or ticks produce output once finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && phase_q == PH_FINISHED |-> !res_emit)
    else $error("result produced while finished");

  // Every last-marked result leaves the block finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_emit && res_last |=> phase_q == PH_FINISHED)
    else $error("final result without finishing");

  // Payload and discard phases always have bytes left to consume
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD || phase_q == PH_DISCARD) |-> bytes_rem_q != '0)
    else $error("byte phase with nothing remaining");

  // The too-big flag only lives while skipping a payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_after_q |-> phase_q == PH_DISCARD)
    else $error("finish flag outside discard");
`endif

endmodule
